// ===== design/icr_pkg.sv =====
// ----------------------------------------------------------------------------
// Impulse collision response package
// Word format, fixed-point constants and the transfer types of both channels.
// ----------------------------------------------------------------------------
package icr_pkg;

    localparam int WORD_WIDTH = 32;      // signed Q16.16 words
    localparam int FRAC_BITS  = 16;      // fraction bits of a word
    localparam int NRM_BITS   = 30;      // contact normal is Q2.30
    localparam int WT_BITS    = 24;      // mass weights are Q1.24
    localparam int TOT_BITS   = 39;      // mass sum is halved below 2^39
    localparam int REST_WIDTH = 17;      // restitution, unsigned Q1.16

    localparam logic [REST_WIDTH-1:0] REST_RESET = 17'd52429;
    localparam int ONE_Q16 = 65536;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] first_pos_x;
        logic signed [WORD_WIDTH-1:0] first_pos_y;
        logic signed [WORD_WIDTH-1:0] first_vel_x;
        logic signed [WORD_WIDTH-1:0] first_vel_y;
        logic        [WORD_WIDTH-1:0] first_mass;
        logic signed [WORD_WIDTH-1:0] second_pos_x;
        logic signed [WORD_WIDTH-1:0] second_pos_y;
        logic signed [WORD_WIDTH-1:0] second_vel_x;
        logic signed [WORD_WIDTH-1:0] second_vel_y;
        logic        [WORD_WIDTH-1:0] second_mass;
    } pair_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] new_first_vel_x;
        logic signed [WORD_WIDTH-1:0] new_first_vel_y;
        logic signed [WORD_WIDTH-1:0] new_second_vel_x;
        logic signed [WORD_WIDTH-1:0] new_second_vel_y;
        logic                         impulse_applied;
    } resp_t;

endpackage

// ===== design/impulse_collision_response.sv =====
// ----------------------------------------------------------------------------
// Impulse collision response
// Restitution impulse between two 2D bodies along their unit contact normal.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction  Transfer when
//  pair      pair_valid, pair_stall, pair     in         valid high, stall low
//  resp      resp_valid, resp_stall, resp     out        valid high, stall low
//  config    cfg_we, cfg_wdata                in         cfg_we high
//
// One pair enters per cycle unless a stalled result holds the stages.
// The stage chain holds the bit-serial square root (32 stages) and the normal
// divider (31 stages). Reset clears the valid bits and loads
// the restitution register with 0.8. A stalled result freezes every stage, so
// the input stalls in the same cycle and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module impulse_collision_response
    import icr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REST_WIDTH-1:0] cfg_wdata,
    input  logic                  pair_valid,
    output logic                  pair_stall,
    input  pair_t                 pair,
    output logic                  resp_valid,
    input  logic                  resp_stall,
    output resp_t                 resp
);

    localparam int W   = WORD_WIDTH;
    localparam int NB  = NRM_BITS;
    localparam int WB  = WT_BITS;
    localparam int PB  = $clog2(W + 1);
    localparam int NW  = NB + 1;          // normal magnitude, at most 2^30
    localparam int QW  = WB + 1;          // weight, at most 2^24
    localparam int LW  = NW + 1;          // vector length
    localparam int RW2 = 2 * NW + 2;      // root extraction word
    localparam int NSQ = LW;              // root bits
    localparam int CW  = REST_WIDTH + 1;  // 1 + restitution
    localparam int KW  = W + 3;           // impulse magnitude
    localparam int VW  = W + 1;           // |vn|
    localparam int RL  = W / 2;
    localparam int RH  = W - RL;
    localparam int VL  = VW / 2;
    localparam int VH  = VW - VL;
    localparam int KL  = KW / 2;
    localparam int KH  = KW - KL;
    localparam int NH  = (W > TOT_BITS - 1) ? W - (TOT_BITS - 1) : 1;

    localparam int L_PRI = 1;
    localparam int L_SHF = 2;
    localparam int L_SQR = 3;
    localparam int L_SUM = 4;
    localparam int L_SQ0 = 5;
    localparam int L_DI  = L_SQ0 + NSQ;
    localparam int L_DS0 = L_DI + 1;
    localparam int L_M1P = L_DS0 + NW;
    localparam int L_M1C = L_M1P + 1;
    localparam int L_VN  = L_M1C + 1;
    localparam int L_M2P = L_VN + 1;
    localparam int L_M2C = L_M2P + 1;
    localparam int L_M3P = L_M2C + 1;
    localparam int L_M3C = L_M3P + 1;
    localparam int L_M4P = L_M3C + 1;
    localparam int L_M4C = L_M4P + 1;
    localparam int L_OUT = L_M4C + 1;
    localparam int DEPTH = L_OUT + 1;
    localparam int L_HV0 = 1;
    localparam int L_WI  = L_HV0 + NH;
    localparam int L_WS0 = L_WI + 1;

    typedef struct packed {
        logic signed [W-1:0]       v1x;
        logic signed [W-1:0]       v1y;
        logic signed [W-1:0]       v2x;
        logic signed [W-1:0]       v2y;
        logic [W-1:0]              m1;
        logic [W-1:0]              m2;
        logic [W:0]                ax;
        logic [W:0]                ay;
        logic                      sx;
        logic                      sy;
        logic                      dz;
        logic [PB-1:0]             msb;
        logic [NW-1:0]             nax;
        logic [NW-1:0]             nay;
        logic [2*NW-1:0]           sqx;
        logic [2*NW-1:0]           sqy;
        logic [RW2-1:0]            srem;
        logic [RW2-1:0]            root;
        logic [LW-1:0]             len;
        logic [LW:0]               drx;
        logic [LW:0]               dry;
        logic [NW-1:0]             qx;
        logic [NW-1:0]             qy;
        logic [W-1:0]              rvxm;
        logic [W-1:0]              rvym;
        logic                      rvxs;
        logic                      rvys;
        logic [RL+NW-1:0]          p1xl;
        logic [RL+NW-1:0]          p1yl;
        logic [RH+NW-1:0]          p1xh;
        logic [RH+NW-1:0]          p1yh;
        logic signed [W:0]         tx;
        logic signed [W:0]         ty;
        logic signed [W+1:0]       vn;
        logic                      applied;
        logic [VW-1:0]             vnm;
        logic [VL+CW-1:0]          p2l;
        logic [VH+CW-1:0]          p2h;
        logic [KW-1:0]             k;
        logic [W:0]                tot;
        logic                      zt;
        logic [W+1:0]              wr1;
        logic [W+1:0]              wr2;
        logic [QW-1:0]             w1;
        logic [QW-1:0]             w2;
        logic [KL+QW-1:0]          p3l1;
        logic [KL+QW-1:0]          p3l2;
        logic [KH+QW-1:0]          p3h1;
        logic [KH+QW-1:0]          p3h2;
        logic [KW-1:0]             g1;
        logic [KW-1:0]             g2;
        logic [3:0][KL+NW-1:0]     p4l;
        logic [3:0][KH+NW-1:0]     p4h;
        logic [3:0][KW-1:0]        dv;
        resp_t                     r;
    } stage_t;

    logic [REST_WIDTH-1:0] rest_reg;
    logic [DEPTH-1:0]      valid_reg;
    stage_t                pipe_reg  [DEPTH];
    stage_t                pipe_next [DEPTH];
    logic                  adv;

    function automatic logic signed [W-1:0] sat_word(input logic signed [W+4:0] v);
        logic signed [W-1:0] res;
        if (v[W+4:W-1] == {6{v[W+4]}})
        begin
            res = v[W-1:0];
        end
        else if (v[W+4])
        begin
            res = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(W-1){1'b1}}};
        end
        return res;
    endfunction

    assign adv        = !valid_reg[DEPTH-1] || !resp_stall;
    assign pair_stall = !adv;
    assign resp_valid = valid_reg[DEPTH-1];
    assign resp       = pipe_reg[DEPTH-1].r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= REST_RESET;
        end
        else if (cfg_we)
        begin
            rest_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], pair_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_next;
        end
    end

    for (genvar s = 0; s < DEPTH; s++)
    begin : g_stage
        stage_t nxt;

        assign pipe_next[s] = nxt;

        if (s == 0)
        begin : g_load
            always_comb
            begin : load_comb
                logic signed [W:0] dx;
                logic signed [W:0] dy;
                logic signed [W:0] rvx;
                logic signed [W:0] rvy;
                nxt     = '0;
                dx      = (W+1)'(pair.first_pos_x) - (W+1)'(pair.second_pos_x);
                dy      = (W+1)'(pair.first_pos_y) - (W+1)'(pair.second_pos_y);
                rvx     = (W+1)'(pair.first_vel_x) - (W+1)'(pair.second_vel_x);
                rvy     = (W+1)'(pair.first_vel_y) - (W+1)'(pair.second_vel_y);
                nxt.v1x = pair.first_vel_x;
                nxt.v1y = pair.first_vel_y;
                nxt.v2x = pair.second_vel_x;
                nxt.v2y = pair.second_vel_y;
                nxt.m1  = pair.first_mass;
                nxt.m2  = pair.second_mass;
                nxt.sx  = dx[W];
                nxt.sy  = dy[W];
                nxt.ax  = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
                nxt.ay  = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
                nxt.rvxs = rvx[W];
                nxt.rvys = rvy[W];
                nxt.rvxm = rvx[W] ? W'(-rvx) : W'(rvx);
                nxt.rvym = rvy[W] ? W'(-rvy) : W'(rvy);
            end
        end
        else
        begin : g_work
            localparam int SQJ = (NSQ - 1) - (s - L_SQ0);
            localparam int DVI = NB - (s - L_DS0);
            localparam int WVI = WB - (s - L_WS0);

            always_comb
            begin : work_comb
                logic [W:0]          mx;
                logic [RW2-1:0]      sbit;
                logic [RW2-1:0]      trial;
                logic [LW:0]         dshx;
                logic [LW:0]         dshy;
                logic [W+1:0]        wsh1;
                logic [W+1:0]        wsh2;
                logic [W+NW-1:0]     f1x;
                logic [W+NW-1:0]     f1y;
                logic [W-1:0]        mag_x;
                logic [W-1:0]        mag_y;
                logic [CW-1:0]       c;
                logic [VW+CW-1:0]    f2;
                logic [QW-1:0]       we1;
                logic [QW-1:0]       we2;
                logic [KW+QW-1:0]    f3a;
                logic [KW+QW-1:0]    f3b;
                logic [KW-1:0]       gsel;
                logic [NW-1:0]       nsel;
                logic [KW+NW-1:0]    f4;
                logic signed [W+4:0] d0;
                logic signed [W+4:0] d1;
                logic signed [W+4:0] d2;
                logic signed [W+4:0] d3;

                nxt = pipe_reg[s-1];
                mx = '0; sbit = '0; trial = '0; dshx = '0; dshy = '0;
                wsh1 = '0; wsh2 = '0; f1x = '0; f1y = '0; mag_x = '0; mag_y = '0;
                c = '0; f2 = '0; we1 = '0; we2 = '0; f3a = '0; f3b = '0;
                gsel = '0; nsel = '0; f4 = '0; d0 = '0; d1 = '0; d2 = '0; d3 = '0;

                // Position path: scale the difference so its larger side has its
                // top bit at position 30.
                if (s == L_PRI)
                begin
                    mx = (nxt.ax > nxt.ay) ? nxt.ax : nxt.ay;
                    nxt.dz  = (mx == '0);
                    nxt.msb = '0;
                    for (int i = 0; i <= W; i++)
                    begin
                        if (mx[i])
                        begin
                            nxt.msb = PB'(i);
                        end
                    end
                end
                if (s == L_SHF)
                begin
                    if (nxt.msb > PB'(NB))
                    begin
                        nxt.nax = NW'(nxt.ax >> (nxt.msb - PB'(NB)));
                        nxt.nay = NW'(nxt.ay >> (nxt.msb - PB'(NB)));
                    end
                    else
                    begin
                        nxt.nax = NW'(nxt.ax) << (PB'(NB) - nxt.msb);
                        nxt.nay = NW'(nxt.ay) << (PB'(NB) - nxt.msb);
                    end
                end
                if (s == L_SQR)
                begin
                    nxt.sqx = (2*NW)'(nxt.nax) * (2*NW)'(nxt.nax);
                    nxt.sqy = (2*NW)'(nxt.nay) * (2*NW)'(nxt.nay);
                end
                if (s == L_SUM)
                begin
                    nxt.srem = RW2'(nxt.sqx) + RW2'(nxt.sqy);
                    nxt.root = '0;
                end
                if (s >= L_SQ0 && s < L_DI)
                begin
                    sbit  = RW2'(1) << ((SQJ >= 0) ? 2 * SQJ : 0);
                    trial = nxt.root + sbit;
                    if (nxt.srem >= trial)
                    begin
                        nxt.srem = nxt.srem - trial;
                        nxt.root = (nxt.root >> 1) + sbit;
                    end
                    else
                    begin
                        nxt.root = nxt.root >> 1;
                    end
                end
                if (s == L_DI)
                begin
                    nxt.len = nxt.root[LW-1:0];
                    nxt.drx = (LW+1)'(nxt.nax >> 1);
                    nxt.dry = (LW+1)'(nxt.nay >> 1);
                    nxt.qx  = '0;
                    nxt.qy  = '0;
                end
                if (s >= L_DS0 && s < L_M1P)
                begin
                    // The only nonzero numerator bit below the start remainder
                    // is bit 0 of the scaled component.
                    dshx = {nxt.drx[LW-1:0], (DVI == NB) ? nxt.nax[0] : 1'b0};
                    dshy = {nxt.dry[LW-1:0], (DVI == NB) ? nxt.nay[0] : 1'b0};
                    if (dshx >= {1'b0, nxt.len})
                    begin
                        nxt.drx = dshx - {1'b0, nxt.len};
                        nxt.qx  = {nxt.qx[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        nxt.drx = dshx;
                        nxt.qx  = {nxt.qx[NW-2:0], 1'b0};
                    end
                    if (dshy >= {1'b0, nxt.len})
                    begin
                        nxt.dry = dshy - {1'b0, nxt.len};
                        nxt.qy  = {nxt.qy[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        nxt.dry = dshy;
                        nxt.qy  = {nxt.qy[NW-2:0], 1'b0};
                    end
                end

                // Mass path: halve both masses until the sum fits, then divide.
                if (s >= L_HV0 && s < L_WI)
                begin
                    nxt.tot = (W+1)'(nxt.m1) + (W+1)'(nxt.m2);
                    if ((nxt.tot >> TOT_BITS) != '0)
                    begin
                        nxt.m1 = nxt.m1 >> 1;
                        nxt.m2 = nxt.m2 >> 1;
                    end
                end
                if (s == L_WI)
                begin
                    nxt.tot = (W+1)'(nxt.m1) + (W+1)'(nxt.m2);
                    nxt.zt  = (nxt.tot == '0);
                    nxt.wr1 = (W+2)'(nxt.m2 >> 1);
                    nxt.wr2 = (W+2)'(nxt.m1 >> 1);
                    nxt.w1  = '0;
                    nxt.w2  = '0;
                end
                if (s >= L_WS0 && s < L_WS0 + QW)
                begin
                    wsh1 = {nxt.wr1[W:0], (WVI == WB) ? nxt.m2[0] : 1'b0};
                    wsh2 = {nxt.wr2[W:0], (WVI == WB) ? nxt.m1[0] : 1'b0};
                    if (wsh1 >= (W+2)'(nxt.tot))
                    begin
                        nxt.wr1 = wsh1 - (W+2)'(nxt.tot);
                        nxt.w1  = {nxt.w1[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        nxt.wr1 = wsh1;
                        nxt.w1  = {nxt.w1[QW-2:0], 1'b0};
                    end
                    if (wsh2 >= (W+2)'(nxt.tot))
                    begin
                        nxt.wr2 = wsh2 - (W+2)'(nxt.tot);
                        nxt.w2  = {nxt.w2[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        nxt.wr2 = wsh2;
                        nxt.w2  = {nxt.w2[QW-2:0], 1'b0};
                    end
                end

                // Velocity projection onto the normal.
                if (s == L_M1P)
                begin
                    if (nxt.dz)
                    begin
                        nxt.qx = '0;
                        nxt.qy = '0;
                    end
                    nxt.p1xl = (RL+NW)'(nxt.rvxm[RL-1:0]) * (RL+NW)'(nxt.qx);
                    nxt.p1yl = (RL+NW)'(nxt.rvym[RL-1:0]) * (RL+NW)'(nxt.qy);
                    nxt.p1xh = (RH+NW)'(nxt.rvxm[W-1:RL]) * (RH+NW)'(nxt.qx);
                    nxt.p1yh = (RH+NW)'(nxt.rvym[W-1:RL]) * (RH+NW)'(nxt.qy);
                end
                if (s == L_M1C)
                begin
                    f1x   = ((W+NW)'(nxt.p1xh) << RL) + (W+NW)'(nxt.p1xl);
                    f1y   = ((W+NW)'(nxt.p1yh) << RL) + (W+NW)'(nxt.p1yl);
                    mag_x = f1x[NB +: W];
                    mag_y = f1y[NB +: W];
                    nxt.tx = (nxt.rvxs ^ nxt.sx) ? -$signed({1'b0, mag_x})
                                                 : $signed({1'b0, mag_x});
                    nxt.ty = (nxt.rvys ^ nxt.sy) ? -$signed({1'b0, mag_y})
                                                 : $signed({1'b0, mag_y});
                end
                if (s == L_VN)
                begin
                    nxt.vn      = (W+2)'(nxt.tx) + (W+2)'(nxt.ty);
                    nxt.applied = (nxt.vn <= 0);
                    nxt.vnm     = nxt.applied ? VW'(-nxt.vn) : '0;
                end

                // Impulse magnitude, then the share of each body.
                if (s == L_M2P)
                begin
                    c = CW'(ONE_Q16) + CW'(rest_reg);
                    nxt.p2l = (VL+CW)'(nxt.vnm[VL-1:0]) * (VL+CW)'(c);
                    nxt.p2h = (VH+CW)'(nxt.vnm[VW-1:VL]) * (VH+CW)'(c);
                end
                if (s == L_M2C)
                begin
                    f2    = ((VW+CW)'(nxt.p2h) << VL) + (VW+CW)'(nxt.p2l);
                    nxt.k = f2[FRAC_BITS +: KW];
                end
                if (s == L_M3P)
                begin
                    we1 = nxt.zt ? QW'(1) << (WB - 1) : nxt.w1;
                    we2 = nxt.zt ? QW'(1) << (WB - 1) : nxt.w2;
                    nxt.p3l1 = (KL+QW)'(nxt.k[KL-1:0]) * (KL+QW)'(we1);
                    nxt.p3l2 = (KL+QW)'(nxt.k[KL-1:0]) * (KL+QW)'(we2);
                    nxt.p3h1 = (KH+QW)'(nxt.k[KW-1:KL]) * (KH+QW)'(we1);
                    nxt.p3h2 = (KH+QW)'(nxt.k[KW-1:KL]) * (KH+QW)'(we2);
                end
                if (s == L_M3C)
                begin
                    f3a    = ((KW+QW)'(nxt.p3h1) << KL) + (KW+QW)'(nxt.p3l1);
                    f3b    = ((KW+QW)'(nxt.p3h2) << KL) + (KW+QW)'(nxt.p3l2);
                    nxt.g1 = f3a[WB +: KW];
                    nxt.g2 = f3b[WB +: KW];
                end
                if (s == L_M4P)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        gsel = (j < 2) ? nxt.g1 : nxt.g2;
                        nsel = (j % 2 == 0) ? nxt.qx : nxt.qy;
                        nxt.p4l[j] = (KL+NW)'(gsel[KL-1:0]) * (KL+NW)'(nsel);
                        nxt.p4h[j] = (KH+NW)'(gsel[KW-1:KL]) * (KH+NW)'(nsel);
                    end
                end
                if (s == L_M4C)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        f4 = ((KW+NW)'(nxt.p4h[j]) << KL) + (KW+NW)'(nxt.p4l[j]);
                        nxt.dv[j] = f4[NB +: KW];
                    end
                end
                if (s == L_OUT)
                begin
                    d0 = $signed((W+5)'(nxt.dv[0]));
                    d1 = $signed((W+5)'(nxt.dv[1]));
                    d2 = $signed((W+5)'(nxt.dv[2]));
                    d3 = $signed((W+5)'(nxt.dv[3]));
                    if (nxt.sx)
                    begin
                        d0 = -d0;
                        d2 = -d2;
                    end
                    if (nxt.sy)
                    begin
                        d1 = -d1;
                        d3 = -d3;
                    end
                    nxt.r.impulse_applied = nxt.applied;
                    if (nxt.applied)
                    begin
                        nxt.r.new_first_vel_x  = sat_word((W+5)'(nxt.v1x) + d0);
                        nxt.r.new_first_vel_y  = sat_word((W+5)'(nxt.v1y) + d1);
                        nxt.r.new_second_vel_x = sat_word((W+5)'(nxt.v2x) - d2);
                        nxt.r.new_second_vel_y = sat_word((W+5)'(nxt.v2y) - d3);
                    end
                    else
                    begin
                        nxt.r.new_first_vel_x  = nxt.v1x;
                        nxt.r.new_first_vel_y  = nxt.v1y;
                        nxt.r.new_second_vel_x = nxt.v2x;
                        nxt.r.new_second_vel_y = nxt.v2y;
                    end
                end
            end
        end
    end

    // The scaled difference always yields a length of at least 2^30.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[L_DI] && !pipe_reg[L_DI].dz |-> pipe_reg[L_DI].len[LW-1:NB] != '0)
        else $error("contact length below normalized range");

    // Normal components never exceed 1.0 in Q2.30.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[L_M1P-1] && !pipe_reg[L_M1P-1].dz |->
            pipe_reg[L_M1P-1].qx <= NW'(1) << NB && pipe_reg[L_M1P-1].qy <= NW'(1) << NB)
        else $error("contact normal component out of range");

    // The two mass weights add up to 1.0 less at most one unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[L_WS0+QW-1] && !pipe_reg[L_WS0+QW-1].zt |->
            (QW+1)'(pipe_reg[L_WS0+QW-1].w1) + (QW+1)'(pipe_reg[L_WS0+QW-1].w2)
                <= (QW+1)'(1) << WB &&
            (QW+1)'(pipe_reg[L_WS0+QW-1].w1) + (QW+1)'(pipe_reg[L_WS0+QW-1].w2)
                >= ((QW+1)'(1) << WB) - (QW+1)'(1))
        else $error("mass weights do not sum to one");

    // A stalled result holds every stage in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp_stall |=> $stable(valid_reg))
        else $error("stage valid bits moved during a stall");

endmodule

// ===== tb/impulse_collision_response_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Impulse collision response checker
// Watches the pair and response channels and predicts each response from the
// accepted pair and the current restitution. It compares every field of each
// response transfer in order and counts the mismatches.
// ----------------------------------------------------------------------------
module impulse_collision_response_checker
    import icr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REST_WIDTH-1:0] cfg_wdata,
    input  logic                  pair_valid,
    input  logic                  pair_stall,
    input  pair_t                 pair,
    input  logic                  resp_valid,
    input  logic                  resp_stall,
    input  resp_t                 resp,
    output int                    error_count,
    output int                    pending
);

    logic [REST_WIDTH-1:0] rest_q;
    resp_t                 expected_resp[$];
    int                    mismatch_count = 0;

    assign pending     = expected_resp.size();
    assign error_count = mismatch_count;

    // Unsigned (a*b) >> sh on the full product, capped at 2^62.
    function automatic logic [63:0] umul_shift(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        logic [127:0] r;
        p = {64'd0, a} * {64'd0, b};
        r = p >> sh;
        if (r > (128'd1 << 62))
            r = 128'd1 << 62;
        return r[63:0];
    endfunction

    function automatic longint smul_shift(longint a, longint b, int sh);
        longint m;
        logic [63:0] ua;
        logic [63:0] ub;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        m  = umul_shift(ua, ub, sh);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [WORD_WIDTH-1:0] sat_word(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[WORD_WIDTH-1:0];
    endfunction

    function automatic resp_t predict_response(pair_t p, logic [REST_WIDTH-1:0] e);
        resp_t       r;
        longint      dx, dy, nx, ny, vn, k, g1, g2;
        logic [63:0] ax, ay, mx, len, m1, m2, tot, w1, w2;
        dx = longint'(p.first_pos_x) - longint'(p.second_pos_x);
        dy = longint'(p.first_pos_y) - longint'(p.second_pos_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        mx = (ax > ay) ? ax : ay;
        nx = 0;
        ny = 0;
        if (mx != 0)
        begin
            while (mx >= (64'd1 << 31))
            begin
                ax = ax >> 1; ay = ay >> 1; mx = mx >> 1;
            end
            while (mx < (64'd1 << 30))
            begin
                ax = ax << 1; ay = ay << 1; mx = mx << 1;
            end
            len = int_sqrt(ax * ax + ay * ay);
            nx  = (ax << NRM_BITS) / len;
            ny  = (ay << NRM_BITS) / len;
            if (dx < 0) nx = -nx;
            if (dy < 0) ny = -ny;
        end
        vn = smul_shift(longint'(p.first_vel_x) - longint'(p.second_vel_x), nx, NRM_BITS)
           + smul_shift(longint'(p.first_vel_y) - longint'(p.second_vel_y), ny, NRM_BITS);
        r.new_first_vel_x  = p.first_vel_x;
        r.new_first_vel_y  = p.first_vel_y;
        r.new_second_vel_x = p.second_vel_x;
        r.new_second_vel_y = p.second_vel_y;
        r.impulse_applied  = 1'b0;
        if (vn <= 0)
        begin
            k   = smul_shift(-vn, longint'(ONE_Q16) + longint'(e), FRAC_BITS);
            m1  = p.first_mass;
            m2  = p.second_mass;
            tot = m1 + m2;
            while (tot >= (64'd1 << TOT_BITS))
            begin
                m1 = m1 >> 1; m2 = m2 >> 1; tot = m1 + m2;
            end
            if (tot == 0)
            begin
                w1 = 64'd1 << (WT_BITS - 1);
                w2 = w1;
            end
            else
            begin
                w1 = (m2 << WT_BITS) / tot;
                w2 = (m1 << WT_BITS) / tot;
            end
            g1 = smul_shift(k, w1, WT_BITS);
            g2 = smul_shift(k, w2, WT_BITS);
            r.new_first_vel_x  = sat_word(longint'(p.first_vel_x) + smul_shift(g1, nx, NRM_BITS));
            r.new_first_vel_y  = sat_word(longint'(p.first_vel_y) + smul_shift(g1, ny, NRM_BITS));
            r.new_second_vel_x = sat_word(longint'(p.second_vel_x) - smul_shift(g2, nx, NRM_BITS));
            r.new_second_vel_y = sat_word(longint'(p.second_vel_y) - smul_shift(g2, ny, NRM_BITS));
            r.impulse_applied  = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        resp_t want;
        if (!rst_n)
            rest_q <= REST_RESET;
        else
        begin
            if (cfg_we)
                rest_q <= cfg_wdata;
            if (pair_valid && !pair_stall)
                expected_resp.push_back(predict_response(pair, rest_q));
            if (resp_valid && !resp_stall)
            begin
                if (expected_resp.size() == 0)
                begin
                    $display("%0t response transfer with nothing expected", $realtime);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_resp.pop_front();
                    if (resp.new_first_vel_x !== want.new_first_vel_x)
                        report_mismatch("new_first_vel_x", resp.new_first_vel_x,
                                        want.new_first_vel_x);
                    if (resp.new_first_vel_y !== want.new_first_vel_y)
                        report_mismatch("new_first_vel_y", resp.new_first_vel_y,
                                        want.new_first_vel_y);
                    if (resp.new_second_vel_x !== want.new_second_vel_x)
                        report_mismatch("new_second_vel_x", resp.new_second_vel_x,
                                        want.new_second_vel_x);
                    if (resp.new_second_vel_y !== want.new_second_vel_y)
                        report_mismatch("new_second_vel_y", resp.new_second_vel_y,
                                        want.new_second_vel_y);
                    if (resp.impulse_applied !== want.impulse_applied)
                        report_mismatch("impulse_applied", resp.impulse_applied,
                                        want.impulse_applied);
                end
            end
        end
    end

endmodule

// ===== tb/impulse_collision_response_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Impulse collision response testbench
// Drives directed and random body pairs under several restitution settings,
// with random idle cycles on both channels; the checker judges each response.
// ----------------------------------------------------------------------------
module impulse_collision_response_tb
    import icr_pkg::*;
();

    localparam int LATENCY     = 78;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [REST_WIDTH-1:0] cfg_wdata = '0;
    logic                  pair_valid = 1'b0;
    logic                  pair_stall;
    pair_t                 pair = '0;
    logic                  resp_valid;
    logic                  resp_stall = 1'b0;
    resp_t                 resp;
    int                    error_count;
    int                    pending;
    int                    cycle_count = 0;
    bit                    steady = 1'b0;   // no idling on either side

    always #6 clk = ~clk;

    impulse_collision_response u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
        .resp_valid(resp_valid), .resp_stall(resp_stall), .resp(resp)
    );

    impulse_collision_response_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
        .resp_valid(resp_valid), .resp_stall(resp_stall), .resp(resp),
        .error_count(error_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        resp_stall  <= !steady && ($urandom_range(99) < 7);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom_range(255) - 128;
            3:       return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(9))
            0:       return 32'hffffffff;
            1:       return 32'd1;
            2:       return 32'd0;
            3:       return $urandom_range(32'h0010_0000, 32'h0000_1000);
            default: return $urandom();
        endcase
    endfunction

    // Random pairs; about half of them approach and take the impulse path.
    function automatic pair_t random_pair();
        pair_t p;
        p.first_pos_x  = rand_word();
        p.first_pos_y  = rand_word();
        p.second_pos_x = ($urandom_range(15) == 0) ? p.first_pos_x : rand_word();
        p.second_pos_y = ($urandom_range(15) == 0) ? p.first_pos_y : rand_word();
        p.first_vel_x  = rand_word();
        p.first_vel_y  = rand_word();
        p.second_vel_x = rand_word();
        p.second_vel_y = rand_word();
        p.first_mass   = rand_mass();
        p.second_mass  = rand_mass();
        return p;
    endfunction

    task automatic send_pair(pair_t p);
        while (!steady && $urandom_range(99) < 7)
        begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair       <= p;
        pair_valid <= 1'b1;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        pair_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_restitution(logic [REST_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        pair_t p;
        logic [REST_WIDTH-1:0] settings[5];
        settings = '{17'd52429, 17'd0, 17'd65536, 17'h1ffff, 17'd32768};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs under the reset restitution.
        p = '0;
        p.first_pos_x = 32'sh0001_0000;
        p.first_vel_x = -32'sh0001_0000;
        p.first_mass = 32'h0001_0000;
        p.second_mass = 32'h0001_0000;
        send_pair(p);                                  // head-on approach
        p.first_vel_x = 32'sh0001_0000;
        send_pair(p);                                  // separating
        p.first_pos_x = 0;
        send_pair(p);                                  // coincident positions
        p.first_pos_x = 32'sh0000_0100;
        p.first_vel_x = 32'sh8000_0000;
        p.second_vel_x = 32'sh7fff_ffff;
        send_pair(p);                                  // saturating velocities
        p.first_mass = 0;
        send_pair(p);                                  // one zero mass
        p.second_mass = 0;
        send_pair(p);                                  // both masses zero
        p.first_mass = 32'hffff_ffff;
        p.second_mass = 32'hffff_ffff;
        send_pair(p);                                  // largest masses
        p.first_pos_x = 32'sh7fff_ffff;
        p.first_pos_y = 32'sh8000_0000;
        p.second_pos_x = 32'sh8000_0000;
        p.second_pos_y = 32'sh7fff_ffff;
        send_pair(p);                                  // extreme positions
        p = '1;
        send_pair(p);
        for (int i = 0; i < 12; i++)
            send_pair(random_pair());
        drain();

        // Random phases through several restitution settings.
        for (int s = 0; s < 5; s++)
        begin
            write_restitution(settings[s]);
            steady = (s == 2);
            for (int i = 0; i < 206; i++)
                send_pair(random_pair());
            drain();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
design/icr_pkg.sv
design/impulse_collision_response.sv
tb/impulse_collision_response_checker.sv
tb/impulse_collision_response_tb.sv
